FILE: rtl/gbm_pkg.sv
// ----------------------------------------------------------------------------
// gbm_pkg
// Shared constants, series tables and inter-module words of the Gaussian
// generator.
// ----------------------------------------------------------------------------
package gbm_pkg;

	localparam int UNIFORM_BITS_DEF = 32;
	localparam int SAMPLE_BITS_DEF  = 32;

	localparam int FRAC_W       = 32;
	localparam int LOG_STEPS    = 32;
	localparam int SQRT_STEPS   = 32;
	localparam int SERIES_TERMS = 6;

	localparam logic [24:0] TWO_LN2_Q24 = 25'd23258160;
	localparam logic [31:0] TWO_PI_Q29  = 32'hC90FDAA2;

	localparam logic REG_MEAN    = 1'b0;
	localparam logic REG_STD_DEV = 1'b1;

	localparam int LANE_SIN = 0;
	localparam int LANE_COS = 1;

	localparam logic [7:0] SERIES_DIV [2][SERIES_TERMS] = '{
		'{8'd6, 8'd20, 8'd42, 8'd72, 8'd110, 8'd156},
		'{8'd2, 8'd12, 8'd30, 8'd56, 8'd90,  8'd132}
	};

	localparam logic [31:0] SERIES_RECIP [2][SERIES_TERMS] = '{
		'{32'((64'd1 << 32) / 64'd6),   32'((64'd1 << 32) / 64'd20),
		  32'((64'd1 << 32) / 64'd42),  32'((64'd1 << 32) / 64'd72),
		  32'((64'd1 << 32) / 64'd110), 32'((64'd1 << 32) / 64'd156)},
		'{32'((64'd1 << 32) / 64'd2),   32'((64'd1 << 32) / 64'd12),
		  32'((64'd1 << 32) / 64'd30),  32'((64'd1 << 32) / 64'd56),
		  32'((64'd1 << 32) / 64'd90),  32'((64'd1 << 32) / 64'd132)}
	};

	typedef struct packed {
		logic        valid;
		logic [31:0] radius;
		logic        sin_neg;
		logic [32:0] sin_mag;
		logic        cos_neg;
		logic [32:0] cos_mag;
	} trig_word_t;

endpackage

FILE: rtl/gaussian_box_muller_top.sv
// ----------------------------------------------------------------------------
// gaussian_box_muller_top
// Box-Muller normal generator: two uniform fractions in, two saturated
// Q15.16 normal samples out.
// ----------------------------------------------------------------------------
// Input channel: in_valid / in_stall carry uniform_radius (u1) and
// uniform_angle (u2); a word is taken when in_valid is high and in_stall low.
// Output channel: out_valid / out_stall carry sample and last; each input word
// gives two output words, the sine sample first and the cosine sample with
// last set.
// Configuration: cfg_wen writes cfg_data to mean (index 0, signed Q15.16) or
// std_dev (index 1, unsigned Q16.16); write only while the block is empty.
// The pipeline takes a word every cycle until it fills; sustained throughput
// is one input word per output pair, set by the single output port emitting
// the pair.
// Reset clears all valid bits and the output phase; mean returns to 0 and
// std_dev to 1.0. When out_stall is high the shown word holds, the whole
// pipeline freezes once a further pair is ready, and in_stall rises.
// ----------------------------------------------------------------------------
module gaussian_box_muller_top #(
	parameter int UNIFORM_BITS = gbm_pkg::UNIFORM_BITS_DEF,
	parameter int SAMPLE_BITS  = gbm_pkg::SAMPLE_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [UNIFORM_BITS-1:0] uniform_radius,
	input  logic [UNIFORM_BITS-1:0] uniform_angle,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [SAMPLE_BITS-1:0]  sample,
	output logic                    last,
	input  logic                    cfg_wen,
	input  logic                    cfg_index,
	input  logic [31:0]             cfg_data
);

	localparam int FW = gbm_pkg::FRAC_W;

	logic [31:0] mean_q, std_dev_q;
	logic [FW-1:0] u1_frac, u2_frac;
	logic adv;

	logic        rad_v;
	logic [63:0] r2;
	logic [31:0] rad_angle;
	logic        sq_v;
	logic [31:0] root;
	logic [31:0] sq_angle;
	gbm_pkg::trig_word_t tw;

	generate
		if (UNIFORM_BITS >= FW) begin : g_trim
			assign u1_frac = uniform_radius[UNIFORM_BITS-1 -: FW];
			assign u2_frac = uniform_angle[UNIFORM_BITS-1 -: FW];
		end else begin : g_pad
			assign u1_frac = {uniform_radius, {(FW-UNIFORM_BITS){1'b0}}};
			assign u2_frac = {uniform_angle, {(FW-UNIFORM_BITS){1'b0}}};
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mean_q    <= 32'd0;
			std_dev_q <= 32'd65536;
		end else if (cfg_wen) begin
			case (cfg_index)
				gbm_pkg::REG_MEAN:    mean_q    <= cfg_data;
				gbm_pkg::REG_STD_DEV: std_dev_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign in_stall = !adv;

	gbm_radius u_radius (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_v      (in_valid),
		.u1        (u1_frac),
		.angle_in  (u2_frac),
		.out_v     (rad_v),
		.r2        (r2),
		.angle_out (rad_angle)
	);

	gbm_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_v      (rad_v),
		.n_in      (r2),
		.angle_in  (rad_angle),
		.out_v     (sq_v),
		.root      (root),
		.angle_out (sq_angle)
	);

	gbm_trig u_trig (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.in_v   (sq_v),
		.angle  (sq_angle),
		.radius (root),
		.tw     (tw)
	);

	gbm_out #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.tw        (tw),
		.mean      (mean_q),
		.std_dev   (std_dev_q),
		.out_stall (out_stall),
		.adv       (adv),
		.out_valid (out_valid),
		.sample    (sample),
		.last      (last)
	);

endmodule

FILE: rtl/gbm_radius.sv
// ----------------------------------------------------------------------------
// gbm_radius
// Log term: normalise 1-u1, log2 by one squaring per stage, scale by 2 ln 2.
// ----------------------------------------------------------------------------
module gbm_radius (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        adv,
	input  logic        in_v,
	input  logic [31:0] u1,
	input  logic [31:0] angle_in,
	output logic        out_v,
	output logic [63:0] r2,
	output logic [31:0] angle_out
);

	localparam int N = gbm_pkg::LOG_STEPS;

	logic [N+1:0] v_s;
	logic [31:0]  x_s  [N+1];
	logic [31:0]  f_s  [N+1];
	logic [5:0]   lz_s [N+1];
	logic [31:0]  a_s  [N+2];
	logic [63:0]  r2_s;

	logic [32:0] w;
	logic [32:0] wn;
	logic [5:0]  lz;
	logic [37:0] len;

	always_comb begin
		w  = 33'h1_0000_0000 - {1'b0, u1};
		lz = 6'd0;
		for (int b = 0; b <= 32; b++) begin
			if (w[b]) lz = 6'(32 - b);
		end
		wn = w << lz;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s <= '0;
		else if (adv) v_s <= {v_s[N:0], in_v};
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s[0]  <= wn[32:1];
			f_s[0]  <= '0;
			lz_s[0] <= lz;
			a_s[0]  <= angle_in;
		end
	end

	genvar i;
	generate
		for (i = 0; i < N; i++) begin : g_sq
			localparam logic [31:0] MASK = 32'd1 << (31 - i);
			logic [63:0] sq;
			logic [32:0] t;
			assign sq = 64'(x_s[i]) * 64'(x_s[i]);
			assign t  = sq[63:31];
			always_ff @(posedge clk) begin
				if (adv) begin
					if (t[32]) begin
						x_s[i+1] <= t[32:1];
						f_s[i+1] <= f_s[i] | MASK;
					end else begin
						x_s[i+1] <= t[31:0];
						f_s[i+1] <= f_s[i];
					end
					lz_s[i+1] <= lz_s[i];
					a_s[i+1]  <= a_s[i];
				end
			end
		end
	endgenerate

	assign len = {lz_s[N], 32'd0} - {6'd0, f_s[N]};

	always_ff @(posedge clk) begin
		if (adv) begin
			r2_s     <= {26'd0, len} * {39'd0, gbm_pkg::TWO_LN2_Q24};
			a_s[N+1] <= a_s[N];
		end
	end

	assign out_v     = v_s[N+1];
	assign r2        = r2_s;
	assign angle_out = a_s[N+1];

endmodule

FILE: rtl/gbm_sqrt.sv
// ----------------------------------------------------------------------------
// gbm_sqrt
// Integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module gbm_sqrt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        adv,
	input  logic        in_v,
	input  logic [63:0] n_in,
	input  logic [31:0] angle_in,
	output logic        out_v,
	output logic [31:0] root,
	output logic [31:0] angle_out
);

	localparam int N = gbm_pkg::SQRT_STEPS;

	logic [N-1:0] v_s;
	logic [63:0]  rem_s  [N];
	logic [63:0]  res_s  [N];
	logic [31:0]  a_s    [N];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s <= '0;
		else if (adv) v_s <= {v_s[N-2:0], in_v};
	end

	genvar k;
	generate
		for (k = 0; k < N; k++) begin : g_bit
			localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
			logic [63:0] n_i;
			logic [63:0] r_i;
			logic [31:0] a_i;
			logic [63:0] trial;
			if (k == 0) begin : g_first
				assign n_i = n_in;
				assign r_i = '0;
				assign a_i = angle_in;
			end else begin : g_next
				assign n_i = rem_s[k-1];
				assign r_i = res_s[k-1];
				assign a_i = a_s[k-1];
			end
			assign trial = r_i + BIT;
			always_ff @(posedge clk) begin
				if (adv) begin
					if (n_i >= trial) begin
						rem_s[k] <= n_i - trial;
						res_s[k] <= (r_i >> 1) + BIT;
					end else begin
						rem_s[k] <= n_i;
						res_s[k] <= r_i >> 1;
					end
					a_s[k] <= a_i;
				end
			end
		end
	endgenerate

	assign out_v     = v_s[N-1];
	assign root      = res_s[N-1][31:0];
	assign angle_out = a_s[N-1];

endmodule

FILE: rtl/gbm_trig.sv
// ----------------------------------------------------------------------------
// gbm_trig
// Angle reduction and sine/cosine series, one term every three stages.
// ----------------------------------------------------------------------------
module gbm_trig (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                adv,
	input  logic                in_v,
	input  logic [31:0]         angle,
	input  logic [31:0]         radius,
	output gbm_pkg::trig_word_t tw
);

	localparam int T  = gbm_pkg::SERIES_TERMS;
	localparam int NS = 2 + 3 * T;

	logic [NS-1:0] v_s;
	logic [1:0]    quad_s [NS];
	logic          swap_s [NS];
	logic [31:0]   rad_s  [NS];
	logic [31:0]   x_s;
	logic [31:0]   x2_s   [NS];
	logic [32:0]   term_s [2][NS];
	logic [33:0]   sum_s  [2][NS];
	logic [31:0]   q_s    [2][NS];
	logic [31:0]   est_s  [2][NS];

	logic        v_q;
	logic [31:0] rad_q;
	logic        sn_q, cn_q;
	logic [32:0] sm_q, cm_q;

	logic [29:0] rr;
	logic [61:0] xp;
	logic [63:0] x2p;

	always_comb begin
		rr  = angle[29] ? 30'(31'h4000_0000 - {1'b0, angle[29:0]}) : angle[29:0];
		xp  = 62'(rr) * 62'(gbm_pkg::TWO_PI_Q29);
		x2p = 64'(x_s) * 64'(x_s);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
			v_q <= 1'b0;
		end else if (adv) begin
			v_s <= {v_s[NS-2:0], in_v};
			v_q <= v_s[NS-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s       <= xp[60:29];
			quad_s[0] <= angle[31:30];
			swap_s[0] <= angle[29];
			rad_s[0]  <= radius;
			x2_s[1]   <= x2p[63:32];
			term_s[gbm_pkg::LANE_SIN][1] <= {1'b0, x_s};
			sum_s[gbm_pkg::LANE_SIN][1]  <= {2'b00, x_s};
			term_s[gbm_pkg::LANE_COS][1] <= 33'h1_0000_0000;
			sum_s[gbm_pkg::LANE_COS][1]  <= 34'h1_0000_0000;
		end
	end

	genvar j, l;
	generate
		for (j = 1; j < NS; j++) begin : g_side
			always_ff @(posedge clk) begin
				if (adv) begin
					quad_s[j] <= quad_s[j-1];
					swap_s[j] <= swap_s[j-1];
					rad_s[j]  <= rad_s[j-1];
				end
			end
		end
		for (j = 2; j < NS; j++) begin : g_st
			localparam int K   = (j - 2) / 3;
			localparam int SUB = (j - 2) % 3;
			always_ff @(posedge clk) begin
				if (adv) x2_s[j] <= x2_s[j-1];
			end
			for (l = 0; l < 2; l++) begin : g_lane
				if (SUB == 0) begin : g_mul
					logic [64:0] p;
					assign p = 65'(term_s[l][j-1]) * 65'(x2_s[j-1]);
					always_ff @(posedge clk) begin
						if (adv) begin
							q_s[l][j]   <= p[63:32];
							sum_s[l][j] <= sum_s[l][j-1];
						end
					end
				end else if (SUB == 1) begin : g_est
					logic [63:0] p;
					assign p = 64'(q_s[l][j-1]) * 64'(gbm_pkg::SERIES_RECIP[l][K]);
					always_ff @(posedge clk) begin
						if (adv) begin
							est_s[l][j] <= p[63:32];
							q_s[l][j]   <= q_s[l][j-1];
							sum_s[l][j] <= sum_s[l][j-1];
						end
					end
				end else begin : g_fix
					logic [39:0] ed;
					logic [39:0] rem;
					logic [31:0] tn;
					always_comb begin
						ed  = 40'(est_s[l][j-1]) * 40'(gbm_pkg::SERIES_DIV[l][K]);
						rem = 40'(q_s[l][j-1]) - ed;
						tn  = est_s[l][j-1]
						    + 32'(rem >= 40'(gbm_pkg::SERIES_DIV[l][K]));
					end
					always_ff @(posedge clk) begin
						if (adv) begin
							term_s[l][j] <= {1'b0, tn};
							if (K % 2 == 0) sum_s[l][j] <= sum_s[l][j-1] - 34'(tn);
							else sum_s[l][j] <= sum_s[l][j-1] + 34'(tn);
						end
					end
				end
			end
		end
	endgenerate

	logic [32:0] s0, c0;

	always_comb begin
		if (swap_s[NS-1]) begin
			s0 = sum_s[gbm_pkg::LANE_COS][NS-1][32:0];
			c0 = sum_s[gbm_pkg::LANE_SIN][NS-1][32:0];
		end else begin
			s0 = sum_s[gbm_pkg::LANE_SIN][NS-1][32:0];
			c0 = sum_s[gbm_pkg::LANE_COS][NS-1][32:0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rad_q <= rad_s[NS-1];
			case (quad_s[NS-1])
				2'd0: begin
					sm_q <= s0; sn_q <= 1'b0; cm_q <= c0; cn_q <= 1'b0;
				end
				2'd1: begin
					sm_q <= c0; sn_q <= 1'b0; cm_q <= s0; cn_q <= 1'b1;
				end
				2'd2: begin
					sm_q <= s0; sn_q <= 1'b1; cm_q <= c0; cn_q <= 1'b1;
				end
				default: begin
					sm_q <= c0; sn_q <= 1'b1; cm_q <= s0; cn_q <= 1'b0;
				end
			endcase
		end
	end

	always_comb begin
		tw.valid   = v_q;
		tw.radius  = rad_q;
		tw.sin_neg = sn_q;
		tw.sin_mag = sm_q;
		tw.cos_neg = cn_q;
		tw.cos_mag = cm_q;
	end

endmodule

FILE: rtl/gbm_out.sv
// ----------------------------------------------------------------------------
// gbm_out
// Radius and deviation scaling, mean offset, saturation and the output pair
// register that sends sine then cosine.
// ----------------------------------------------------------------------------
module gbm_out #(
	parameter int SAMPLE_BITS = gbm_pkg::SAMPLE_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  gbm_pkg::trig_word_t    tw,
	input  logic [31:0]            mean,
	input  logic [31:0]            std_dev,
	input  logic                   out_stall,
	output logic                   adv,
	output logic                   out_valid,
	output logic [SAMPLE_BITS-1:0] sample,
	output logic                   last
);

	localparam int VW = 50;
	localparam logic signed [VW-1:0] SAT_HI = VW'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
	localparam logic signed [VW-1:0] SAT_LO = -SAT_HI - VW'(1);

	logic        v_s1, v_s2;
	logic [31:0] zs_s1, zc_s1;
	logic        ns_s1, nc_s1, ns_s2, nc_s2;
	logic [35:0] fs_s2, fc_s2;

	logic                   obuf_v_q, phase_q;
	logic [SAMPLE_BITS-1:0] sin_q, cos_q;

	logic [64:0] ps, pc;
	logic [63:0] qs, qc;
	logic signed [VW-1:0] m, vs, vc, ss, sc;
	logic free;

	always_comb begin
		ps = 65'(tw.radius) * 65'(tw.sin_mag) + 65'h8000_0000;
		pc = 65'(tw.radius) * 65'(tw.cos_mag) + 65'h8000_0000;
		qs = 64'(std_dev) * 64'(zs_s1) + 64'h800_0000;
		qc = 64'(std_dev) * 64'(zc_s1) + 64'h800_0000;
		m  = {{(VW-32){mean[31]}}, mean};
		vs = ns_s2 ? m - VW'(fs_s2) : m + VW'(fs_s2);
		vc = nc_s2 ? m - VW'(fc_s2) : m + VW'(fc_s2);
		ss = (vs > SAT_HI) ? SAT_HI : ((vs < SAT_LO) ? SAT_LO : vs);
		sc = (vc > SAT_HI) ? SAT_HI : ((vc < SAT_LO) ? SAT_LO : vc);
		free = !obuf_v_q || (phase_q && !out_stall);
		adv  = !v_s2 || free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			obuf_v_q <= 1'b0;
			phase_q  <= 1'b0;
		end else begin
			if (adv) begin
				v_s1 <= tw.valid;
				v_s2 <= v_s1;
			end
			if (adv && v_s2) begin
				obuf_v_q <= 1'b1;
				phase_q  <= 1'b0;
			end else if (obuf_v_q && !out_stall) begin
				if (!phase_q) phase_q <= 1'b1;
				else obuf_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			zs_s1 <= ps[63:32];
			zc_s1 <= pc[63:32];
			ns_s1 <= tw.sin_neg;
			nc_s1 <= tw.cos_neg;
			fs_s2 <= qs[63:28];
			fc_s2 <= qc[63:28];
			ns_s2 <= ns_s1;
			nc_s2 <= nc_s1;
			if (v_s2) begin
				sin_q <= ss[SAMPLE_BITS-1:0];
				cos_q <= sc[SAMPLE_BITS-1:0];
			end
		end
	end

	assign out_valid = obuf_v_q;
	assign sample    = phase_q ? cos_q : sin_q;
	assign last      = phase_q;

	a_cos_follows: assert property (@(posedge clk) disable iff (!arst_n)
		obuf_v_q && !phase_q && !out_stall |=> obuf_v_q && phase_q)
		else $error("cosine word did not follow accepted sine word");

	a_load_sine_first: assert property (@(posedge clk) disable iff (!arst_n)
		adv && v_s2 |=> obuf_v_q && !phase_q)
		else $error("loaded pair does not start with the sine word");

	a_hold_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |-> obuf_v_q && v_s2)
		else $error("pipeline held without a waiting pair");

endmodule

FILE: verif/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for gaussian_box_muller_top. Corner and random pairs are
// sent through the block under several mean and std_dev settings; a bit-exact
// fixed-point Box-Muller predictor computes the sine and cosine samples of
// every accepted word, and each output word is checked against the oldest one.
// ----------------------------------------------------------------------------
module tb;

	typedef bit [63:0] u64;
	typedef struct {
		bit [31:0] u1;
		bit [31:0] u2;
	} uniform_pair_t;
	typedef struct {
		bit [31:0] sample;
		bit        last;
	} variate_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [31:0] uniform_radius = '0;
	logic [31:0] uniform_angle = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [31:0] sample;
	logic        last;
	logic        cfg_wen = 1'b0;
	logic        cfg_index = 1'b0;
	logic [31:0] cfg_data = '0;

	uniform_pair_t pair_queue[$];
	variate_t      variate_queue[$];
	bit [31:0]     mean_q = 32'd0;
	bit [31:0]     std_dev_q = 32'd65536;
	bit            in_taken = 1'b0;
	bit            steady = 1'b0;
	int            in_gap = 0;
	int            out_gap = 0;
	int            mismatches = 0;
	int            pairs_sent = 0;
	int            words_checked = 0;

	gaussian_box_muller_top DUT (.*);

	always #6 clk = ~clk;

	function automatic u64 isqrt(u64 n);
		u64 res, b;
		res = 0;
		b = u64'(1) << 62;
		while (b > n) b >>= 2;
		while (b != 0) begin
			if (n >= res + b) begin
				n -= res + b;
				res = (res >> 1) + b;
			end else
				res >>= 1;
			b >>= 2;
		end
		return res;
	endfunction

	function automatic u64 radius_of(bit [31:0] u1);
		u64 w, x, frac, len;
		int e;
		w = (u64'(1) << 32) - u64'(u1);
		frac = 0;
		e = 0;
		while (e < 32 && (w >> (e + 1)) != 0) e++;
		x = (e <= 31) ? (w << (31 - e)) : (w >> 1);
		for (int i = 0; i < 32; i++) begin
			x = (x * x) >> 31;
			if (x >= (u64'(1) << 32)) begin
				x >>= 1;
				frac |= u64'(1) << (31 - i);
			end
		end
		len = (u64'(32 - e) << 32) - frac;
		return isqrt(len * u64'(gbm_pkg::TWO_LN2_Q24));
	endfunction

	function automatic u64 taylor(u64 x, bit is_sin);
		u64 x2, term, sum, d;
		x2 = (x * x) >> 32;
		term = is_sin ? x : (u64'(1) << 32);
		sum = term;
		for (int k = 1; k <= 6; k++) begin
			d = is_sin ? u64'((2 * k) * (2 * k + 1)) : u64'((2 * k - 1) * (2 * k));
			term = ((term * x2) >> 32) / d;
			if (k % 2) sum -= term;
			else sum += term;
		end
		return sum;
	endfunction

	function automatic bit [31:0] scale_to_sample(u64 r, longint trig);
		u64 mag, z, p;
		longint v, m;
		bit neg;
		neg = trig < 0;
		mag = neg ? u64'(-trig) : u64'(trig);
		z = (r * mag + (u64'(1) << 31)) >> 32;
		p = (u64'(std_dev_q) * z + (u64'(1) << 27)) >> 28;
		m = longint'($signed(mean_q));
		v = neg ? m - longint'(p) : m + longint'(p);
		if (v > 64'sd2147483647) v = 64'sd2147483647;
		if (v < -64'sd2147483648) v = -64'sd2147483648;
		return v[31:0];
	endfunction

	task automatic predict_variates(uniform_pair_t pr);
		u64 r, rem, x;
		longint s0, c0, s, c, t;
		bit [1:0] quad;
		r = radius_of(pr.u1);
		quad = pr.u2[31:30];
		rem = u64'(pr.u2[29:0]);
		x = 0;
		if (rem >= (u64'(1) << 29)) rem = (u64'(1) << 30) - rem;
		x = (rem * u64'(gbm_pkg::TWO_PI_Q29)) >> 29;
		s0 = longint'(taylor(x, 1'b1));
		c0 = longint'(taylor(x, 1'b0));
		if (pr.u2[29:0] >= 30'h2000_0000) begin
			t = s0; s0 = c0; c0 = t;
		end
		case (quad)
			2'd0: begin s = s0; c = c0; end
			2'd1: begin s = c0; c = -s0; end
			2'd2: begin s = -s0; c = -c0; end
			default: begin s = -c0; c = s0; end
		endcase
		variate_queue.push_back('{scale_to_sample(r, s), 1'b0});
		variate_queue.push_back('{scale_to_sample(r, c), 1'b1});
	endtask

	function automatic int idle_len();
		int p;
		p = $urandom_range(0, 99);
		if (steady || p < 65) return 0;
		if (p < 94) return $urandom_range(1, 3);
		return $urandom_range(5, 40);
	endfunction

	// driver
	always @(negedge clk) begin
		if (arst_n) begin
			if (!in_valid || in_taken) begin
				if (in_gap > 0) begin
					in_gap <= in_gap - 1;
					in_valid <= 1'b0;
				end else if (pair_queue.size() != 0) begin
					uniform_radius <= pair_queue[0].u1;
					uniform_angle <= pair_queue[0].u2;
					void'(pair_queue.pop_front());
					in_valid <= 1'b1;
					in_gap <= idle_len();
				end else
					in_valid <= 1'b0;
			end
			if (out_gap > 0) begin
				out_gap <= out_gap - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
				out_gap <= idle_len();
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		variate_t want;
		in_taken <= in_valid && !in_stall;
		if (in_valid && !in_stall) begin
			predict_variates('{uniform_radius, uniform_angle});
			pairs_sent++;
		end
		if (out_valid && !out_stall) begin
			words_checked++;
			if (variate_queue.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected word: sample=%h last=%b", sample, last);
			end else begin
				want = variate_queue.pop_front();
				if (sample !== want.sample || last !== want.last) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected sample=%h last=%b, got sample=%h last=%b",
							want.sample, want.last, sample, last);
				end
			end
		end
	end

	task automatic write_reg(logic idx, bit [31:0] val);
		@(negedge clk);
		cfg_wen <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_wen <= 1'b0;
		if (idx == gbm_pkg::REG_MEAN) mean_q = val;
		else std_dev_q = val;
	endtask

	task automatic drain();
		while (pair_queue.size() != 0 || variate_queue.size() != 0 || in_valid)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic add_random_pairs(int n);
		bit [31:0] a;
		for (int i = 0; i < n; i++) begin
			a = $urandom();
			case ($urandom_range(0, 5))
				0: a = a | 32'hFFF0_0000;
				1: a = a >> $urandom_range(0, 31);
				default: ;
			endcase
			pair_queue.push_back('{a, $urandom()});
		end
	endtask

	initial begin
		bit [31:0] dir_u1[6];
		bit [31:0] dir_u2[8];
		dir_u1 = '{32'h0, 32'hFFFF_FFFF, 32'h1, 32'h8000_0000, 32'hFFFF_FFFE, 32'h5555_5555};
		dir_u2 = '{32'h0, 32'h4000_0000, 32'h8000_0000, 32'hC000_0000,
			32'h2000_0000, 32'h1FFF_FFFF, 32'hFFFF_FFFF, 32'h3FFF_FFFF};
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset defaults, directed corners
		for (int i = 0; i < 6; i++)
			for (int j = 0; j < 4; j++)
				pair_queue.push_back('{dir_u1[i], dir_u2[(i + j * 3) % 8]});
		drain();

		for (int ph = 0; ph < 7; ph++) begin
			case (ph)
				0: begin
					write_reg(gbm_pkg::REG_MEAN, 32'h7FFF_FFFF);
					write_reg(gbm_pkg::REG_STD_DEV, 32'hFFFF_FFFF);
				end
				1: begin write_reg(gbm_pkg::REG_MEAN, 32'h8000_0000); end
				2: begin
					write_reg(gbm_pkg::REG_MEAN, 32'h0);
					write_reg(gbm_pkg::REG_STD_DEV, 32'h0);
				end
				3: begin
					write_reg(gbm_pkg::REG_MEAN, $urandom());
					write_reg(gbm_pkg::REG_STD_DEV, $urandom());
				end
				4: begin
					write_reg(gbm_pkg::REG_MEAN, 32'hFFFF_0000);
					write_reg(gbm_pkg::REG_STD_DEV, 32'h0001_0000);
				end
				5: begin
					write_reg(gbm_pkg::REG_MEAN, $urandom());
					write_reg(gbm_pkg::REG_STD_DEV, $urandom() >> 12);
				end
				default: begin
					write_reg(gbm_pkg::REG_MEAN, 32'h0);
					write_reg(gbm_pkg::REG_STD_DEV, 32'h0100_0000);
				end
			endcase
			steady = (ph == 3);
			if (ph < 3)
				for (int i = 0; i < 8; i++)
					pair_queue.push_back('{dir_u1[i % 6], dir_u2[i]});
			add_random_pairs(ph < 3 ? 170 : 230);
			drain();
		end

		$display("Sent %0d uniform pairs over 8 mean/std_dev settings, including saturation,",
			pairs_sent);
		$display("zero scale and quadrant corners; %0d sample words checked.", words_checked);
		if (mismatches == 0)
			$display("gaussian_box_muller_top verification clean");
		else
			$display("gaussian_box_muller_top verification failed");
		$finish;
	end

	initial begin
		#20ms;
		$display("timeout with %0d words outstanding", variate_queue.size());
		$display("gaussian_box_muller_top verification failed");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/gbm_pkg.sv
rtl/gbm_radius.sv
rtl/gbm_sqrt.sv
rtl/gbm_trig.sv
rtl/gbm_out.sv
rtl/gaussian_box_muller_top.sv
verif/tb.sv
